// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types, command codes, character codes and the color palette of the
// text console writer
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   // command codes carried in the item selector
   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // character codes
   localparam logic [7:0] SPACE_CODE     = 8'h20;
   localparam logic [7:0] NEWLINE_CODE   = 8'd10;
   localparam logic [7:0] BACKSPACE_CODE = 8'd8;
   localparam logic [7:0] NULL_CODE      = 8'd0;

   // register map: word index taken from paddr bit 2
   localparam logic       REG_COLOR_ATTR   = 1'b0;
   localparam logic [7:0] COLOR_ATTR_RESET = 8'hf0;

   // one request to the single-port text memory
   typedef struct packed {
      logic en;
      logic we;
   } mem_cmd_type;

   // 16-entry palette, 24-bit rgb
   function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
      logic [23:0] rgb;
      case (idx)
         4'd0:    rgb = 24'h000000;
         4'd1:    rgb = 24'haa0000;
         4'd2:    rgb = 24'h00aa00;
         4'd3:    rgb = 24'haa5500;
         4'd4:    rgb = 24'h0000aa;
         4'd5:    rgb = 24'haa00aa;
         4'd6:    rgb = 24'h00aaaa;
         4'd7:    rgb = 24'haaaaaa;
         4'd8:    rgb = 24'h555555;
         4'd9:    rgb = 24'hff5555;
         4'd10:   rgb = 24'h55ff55;
         4'd11:   rgb = 24'hffff55;
         4'd12:   rgb = 24'h5555ff;
         4'd13:   rgb = 24'hff55ff;
         4'd14:   rgb = 24'h55ffff;
         default: rgb = 24'hffffff;
      endcase
      return rgb;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tcw_store.sv =====
// ----------------------------------------------------------------------------
// tcw_store
// single-port character memory, one access a cycle, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_store
   import tcw_pkg::*;
#(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  wire logic          clock,
   input  wire mem_cmd_type   mem_cmd,
   input  wire logic [AW-1:0] mem_addr,
   input  wire logic [7:0]    mem_wdata,
   output logic [7:0]         mem_rdata
);

   logic [7:0] store_mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.en && mem_cmd.we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
      if (mem_cmd.en && !mem_cmd.we) begin
         rdata_ff <= store_mem[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tcw_csr.sv =====
// ----------------------------------------------------------------------------
// tcw_csr
// apb-style register port holding the color attribute
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_csr
   import tcw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output logic [7:0]       color_attr
);

   logic [7:0] color_attr_ff;
   logic [7:0] color_attr_in;
   logic       wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_COLOR_ATTR);

   always_comb begin
      color_attr_in = color_attr_ff;
      if (wr_hit) begin
         color_attr_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_attr_ff <= COLOR_ATTR_RESET;
      end else begin
         color_attr_ff <= color_attr_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_COLOR_ATTR) ? {24'd0, color_attr_ff} : 32'd0;
   assign color_attr = color_attr_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// command sequencer: cursor, scroll and fill sweeps over the text memory,
// result register
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl
   import tcw_pkg::*;
#(
   parameter int COLS = 80,
   parameter int ROWS = 25,
   parameter int AW   = 11
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [1:0]    req_cmd,
   input  wire logic [7:0]    req_char_code,
   input  wire logic [10:0]   req_cell_index,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [6:0]         rsp_cursor_col,
   output logic [4:0]         rsp_cursor_row,
   output logic               rsp_scrolled,
   output logic [7:0]         rsp_cell_char,
   output logic [23:0]        rsp_fg_rgb,
   output logic [23:0]        rsp_bg_rgb,
   input  wire logic [7:0]    color_attr,
   output mem_cmd_type        mem_cmd,
   output logic [AW-1:0]      mem_addr,
   output logic [7:0]         mem_wdata,
   input  wire logic [7:0]    mem_rdata
);

   localparam int CELLS = COLS * ROWS;
   localparam int CW    = $clog2(COLS);
   localparam int RW    = $clog2(ROWS);

   localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
   localparam logic [AW-1:0] SCROLL_LAST = AW'(CELLS - COLS - 1);
   localparam logic [AW-1:0] BOTTOM_ROW  = AW'(CELLS - COLS);
   localparam logic [CW-1:0] LAST_COL    = CW'(COLS - 1);
   localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);

   localparam logic [2:0] ST_INIT    = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_RD_WAIT = 3'd2;
   localparam logic [2:0] ST_SCR_RD  = 3'd3;
   localparam logic [2:0] ST_SCR_WR  = 3'd4;
   localparam logic [2:0] ST_FILL    = 3'd5;
   localparam logic [2:0] ST_FINISH  = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] k_ff, k_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          scrolled_ff, scrolled_in;
   logic [7:0]    cell_ff, cell_in;
   logic          newline;
   logic          load;
   logic [31:0]   idx_ext;
   logic          idx_in_range;
   logic [AW-1:0] cursor_pos;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [6:0]    rsp_col_ff;
   logic [4:0]    rsp_row_ff;
   logic          rsp_scrolled_ff;
   logic [7:0]    rsp_cell_ff;
   logic [23:0]   rsp_fg_ff;
   logic [23:0]   rsp_bg_ff;

   assign idx_ext      = 32'(req_cell_index);
   assign idx_in_range = idx_ext < 32'(CELLS);
   assign cursor_pos   = AW'(int'(row_ff) * COLS + int'(col_ff));
   assign req_ready    = (state_ff == ST_IDLE);
   assign load         = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      scrolled_in = scrolled_ff;
      cell_in     = cell_ff;
      newline     = 1'b0;
      mem_cmd     = '0;
      mem_addr    = k_ff;
      mem_wdata   = SPACE_CODE;
      case (state_ff)
         ST_INIT, ST_FILL: begin
            mem_cmd.en = 1'b1;
            mem_cmd.we = 1'b1;
            if (k_ff == LAST_CELL) begin
               k_in     = '0;
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_FINISH;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               scrolled_in = 1'b0;
               cell_in     = 8'd0;
               state_in    = ST_FINISH;
               case (req_cmd)
                  CMD_PUT: begin
                     if (req_char_code == NULL_CODE) begin
                        state_in = ST_FINISH;
                     end else if (req_char_code == NEWLINE_CODE) begin
                        newline = 1'b1;
                     end else if (req_char_code == BACKSPACE_CODE) begin
                        if (col_ff != '0) begin
                           col_in = col_ff - 1'b1;
                        end
                     end else begin
                        mem_cmd.en = 1'b1;
                        mem_cmd.we = 1'b1;
                        mem_addr   = cursor_pos;
                        mem_wdata  = req_char_code;
                        if (col_ff == LAST_COL) begin
                           newline = 1'b1;
                        end else begin
                           col_in = col_ff + 1'b1;
                        end
                     end
                  end
                  CMD_CLEAR: begin
                     k_in     = '0;
                     state_in = ST_FILL;
                  end
                  CMD_READ: begin
                     if (idx_in_range) begin
                        mem_cmd.en = 1'b1;
                        mem_addr   = idx_ext[AW-1:0];
                        state_in   = ST_RD_WAIT;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            cell_in  = mem_rdata;
            state_in = ST_FINISH;
         end
         ST_SCR_RD: begin
            mem_cmd.en = 1'b1;
            mem_addr   = AW'(int'(k_ff) + COLS);
            state_in   = ST_SCR_WR;
         end
         ST_SCR_WR: begin
            mem_cmd.en = 1'b1;
            mem_cmd.we = 1'b1;
            mem_wdata  = mem_rdata;
            if (k_ff == SCROLL_LAST) begin
               k_in     = BOTTOM_ROW;
               state_in = ST_FILL;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_SCR_RD;
            end
         end
         ST_FINISH: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // cursor to the start of the next row, scrolling from the last row
      if (newline) begin
         col_in = '0;
         if (row_ff == LAST_ROW) begin
            scrolled_in = 1'b1;
            k_in        = '0;
            state_in    = ST_SCR_RD;
         end else begin
            row_in   = row_ff + 1'b1;
            state_in = ST_FINISH;
         end
      end
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         k_ff         <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scrolled_ff <= scrolled_in;
      cell_ff     <= cell_in;
      if (load) begin
         rsp_col_ff      <= 7'(col_ff);
         rsp_row_ff      <= 5'(row_ff);
         rsp_scrolled_ff <= scrolled_ff;
         rsp_cell_ff     <= cell_ff;
         rsp_fg_ff       <= palette_rgb(color_attr[7:4]);
         rsp_bg_ff       <= palette_rgb(color_attr[3:0]);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;
   assign rsp_cell_char  = rsp_cell_ff;
   assign rsp_fg_rgb     = rsp_fg_ff;
   assign rsp_bg_rgb     = rsp_bg_ff;

   // memory writes stay inside the store
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      (mem_cmd.en && mem_cmd.we) |-> (32'(mem_addr) < 32'(CELLS)))
      else $error("text memory write outside the store");

   // cursor never leaves the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < 32'(COLS)) && (32'(row_ff) < 32'(ROWS)))
      else $error("cursor outside the screen");

   // a scroll sweep runs with the cursor parked at the start of the last row
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCR_RD) || (state_ff == ST_SCR_WR))
      |-> ((row_ff == LAST_ROW) && (col_ff == '0) && scrolled_ff))
      else $error("scroll sweep with cursor off the last row");

   // a finished item is handed to the result register
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("finished item not presented");

   // no item is taken in a fill, a scroll write or the reset clearing pass
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_INIT) || (state_ff == ST_FILL) || (state_ff == ST_SCR_WR))
      |-> !req_ready)
      else $error("item accepted during a sweep");

endmodule

`default_nettype wire

// ===== rtl/core/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// teletype-style text console: a COLS x ROWS character store and a cursor
// ----------------------------------------------------------------------------
// usage
//   req channel: one item per command, req_tuser selects put character, clear
//   screen or read cell, req_tdata carries the character and the cell index.
//   one rsp item per req item, in order: cursor after the command, scroll
//   flag, cell read and the colors chosen by the color_attr register.
//   csr port: apb-style, color_attr at byte address 0, pready always high.
// command steps
//   read of a cell in the store: a memory read, a wait for the read data,
//   then the result register; any other put, read or unused command goes
//   straight to it. the next item waits until the last is loaded there.
//   a put that scrolls moves the rows through the one-port memory: a read
//   and a write per moved cell, then one write per cell of the bottom row.
//   clear writes a space into every cell.
// reset
//   cursor cleared, then a clearing pass writes spaces into every cell
//   with req_tready low; csr writes are taken throughout.
// stall
//   the result waits in an output register while rsp_tready is low; the next
//   item may be accepted and worked on, and waits in its last step for it.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // char_code [7:0], cell_index [18:8], zeros
   input  wire logic [1:0]  req_tuser,   // cmd [1:0]
   // result items
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // cursor_col [6:0], cursor_row [11:7],
                                         // scrolled [12], cell_char [20:13],
                                         // fg_rgb [44:21], bg_rgb [68:45], zeros
   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int CELLS = COLS * ROWS;
   localparam int AW    = $clog2(CELLS);

   logic [7:0]    color_attr;
   mem_cmd_type   mem_cmd;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_wdata;
   logic [7:0]    mem_rdata;

   logic [6:0]    out_col;
   logic [4:0]    out_row;
   logic          out_scrolled;
   logic [7:0]    out_cell;
   logic [23:0]   out_fg;
   logic [23:0]   out_bg;

   // color register
   tcw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .color_attr  (color_attr)
   );

   // character memory, one access a cycle
   tcw_store #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_store (
      .clock     (clock),
      .mem_cmd   (mem_cmd),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   // sequencer and result register
   tcw_ctrl #(
      .COLS (COLS),
      .ROWS (ROWS),
      .AW   (AW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_cmd        (req_tuser),
      .req_char_code  (req_tdata[7:0]),
      .req_cell_index (req_tdata[18:8]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_cursor_col (out_col),
      .rsp_cursor_row (out_row),
      .rsp_scrolled   (out_scrolled),
      .rsp_cell_char  (out_cell),
      .rsp_fg_rgb     (out_fg),
      .rsp_bg_rgb     (out_bg),
      .color_attr     (color_attr),
      .mem_cmd        (mem_cmd),
      .mem_addr       (mem_addr),
      .mem_wdata      (mem_wdata),
      .mem_rdata      (mem_rdata)
   );

   // pack the result fields, lowest field first
   assign rsp_tdata = {3'd0, out_bg, out_fg, out_cell, out_scrolled, out_row, out_col};

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench for text_console_writer
// drives put, clear, read and unused commands into the console, keeps its own
// screen, cursor and color state, and checks every result item field by field
// against that state; color_attr is rewritten between phases while idle
// ----------------------------------------------------------------------------
module testbench;
   import tcw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // console geometry as built
   localparam int SCR_COLS  = 80;
   localparam int SCR_ROWS  = 25;
   localparam int SCR_CELLS = SCR_COLS * SCR_ROWS;

   // command code the block does not use
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // byte address of color_attr on the csr port
   localparam logic [2:0] ADDR_COLOR_ATTR = 3'd0;

   // cycles with no item moving on either channel before the run is declared hung
   localparam int STALL_LIMIT = 40000;

   // fewest random items per phase, one phase per color setting
   localparam int PHASE_ITEMS = 150;

   // palette as rgb, index 0 up to 15
   localparam logic [23:0] RGB_OF [16] = '{
      24'h000000, 24'haa0000, 24'h00aa00, 24'haa5500,
      24'h0000aa, 24'haa00aa, 24'h00aaaa, 24'haaaaaa,
      24'h555555, 24'hff5555, 24'h55ff55, 24'hffff55,
      24'h5555ff, 24'hff55ff, 24'h55ffff, 24'hffffff
   };
   localparam logic [23:0] RGB_BLACK = 24'h000000;
   localparam logic [23:0] RGB_WHITE = 24'hffffff;

   // one result item, unpacked
   typedef struct packed {
      logic [6:0]  col;
      logic [4:0]  row;
      logic        scrolled;
      logic [7:0]  cell_char;
      logic [23:0] fg;
      logic [23:0] bg;
   } console_status_type;

   // one row of the directed table
   typedef struct {
      logic [1:0]         cmd;
      logic [7:0]         code;
      logic [10:0]        idx;
      bit                 typed;
      console_status_type status;
   } directed_row_type;

   // ------------------------------------------------------------------------
   // clock, reset and the block's inputs, all known from time zero
   // ------------------------------------------------------------------------
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;   // char_code [7:0], cell_index [18:8], zeros
   logic [1:0]  req_tuser   = CMD_PUT;   // cmd [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [71:0] rsp_tdata;          // cursor_col [6:0], cursor_row [11:7],
                                    // scrolled [12], cell_char [20:13],
                                    // fg_rgb [44:21], bg_rgb [68:45], zeros
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   always #5 clock = ~clock;

   text_console_writer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ------------------------------------------------------------------------
   // console state as the testbench sees it
   // ------------------------------------------------------------------------
   logic [7:0] screen_mem [SCR_CELLS];
   int         cur_col_m;
   int         cur_row_m;
   logic [7:0] color_attr_m;

   console_status_type due_status_q [$];   // results still to come, oldest first

   int  err_count    = 0;
   int  accepted     = 0;
   int  n_puts       = 0;
   int  n_scrolls    = 0;
   int  n_reads      = 0;
   int  n_clears     = 0;
   int  n_settings   = 0;
   bit  jitter_on    = 1'b1;   // random idling on both sides
   bit  run_done     = 1'b0;

   // move the console to the next row, scrolling at the bottom
   function automatic bit line_feed();
      cur_col_m = 0;
      if (cur_row_m + 1 < SCR_ROWS) begin
         cur_row_m++;
         return 1'b0;
      end
      for (int i = 0; i < SCR_CELLS - SCR_COLS; i++)
         screen_mem[i] = screen_mem[i + SCR_COLS];
      for (int i = SCR_CELLS - SCR_COLS; i < SCR_CELLS; i++)
         screen_mem[i] = SPACE_CODE;
      cur_row_m = SCR_ROWS - 1;
      return 1'b1;
   endfunction

   // apply one command to the console state and give the status it reports
   function automatic console_status_type advance_console(input logic [1:0]  cmd,
                                                          input logic [7:0]  code,
                                                          input logic [10:0] idx);
      console_status_type st;
      st = '0;
      case (cmd)
         CMD_PUT: begin
            n_puts++;
            if (code == NEWLINE_CODE) begin
               st.scrolled = line_feed();
            end else if (code == BACKSPACE_CODE) begin
               if (cur_col_m > 0) cur_col_m--;
            end else if (code != NULL_CODE) begin
               screen_mem[cur_row_m * SCR_COLS + cur_col_m] = code;
               cur_col_m++;
               if (cur_col_m >= SCR_COLS) st.scrolled = line_feed();
            end
            if (st.scrolled) n_scrolls++;
         end
         CMD_CLEAR: begin
            n_clears++;
            foreach (screen_mem[i]) screen_mem[i] = SPACE_CODE;
         end
         CMD_READ: begin
            n_reads++;
            if (idx < SCR_CELLS) st.cell_char = screen_mem[idx];
         end
         default: ;   // unused command changes nothing
      endcase
      st.col = cur_col_m[6:0];
      st.row = cur_row_m[4:0];
      st.fg  = RGB_OF[color_attr_m[7:4]];
      st.bg  = RGB_OF[color_attr_m[3:0]];
      return st;
   endfunction

   // any character the console stores rather than acts on
   function automatic logic [7:0] pick_glyph();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (c == NEWLINE_CODE || c == BACKSPACE_CODE);
      return c;
   endfunction

   // ------------------------------------------------------------------------
   // sender: one item per call, returns at the edge that accepts it
   // ------------------------------------------------------------------------
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] code,
                            input logic [10:0] idx, input bit typed,
                            input console_status_type typed_status);
      console_status_type st;
      if (jitter_on) begin
         while ($urandom_range(99) < 29) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'd0, idx, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // accepted at this edge
      accepted++;
      st = advance_console(cmd, code, idx);
      due_status_q.push_back(typed ? typed_status : st);
   endtask

   task automatic send_random(input logic [1:0] cmd, input logic [7:0] code,
                              input logic [10:0] idx);
      send_item(cmd, code, idx, 1'b0, '0);
   endtask

   // stop sending and wait for every outstanding result, then a short pause
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (due_status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write color_attr, then read it back; called only while idle
   task automatic set_color_attr(input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_COLOR_ATTR;
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // register written at this edge; read phase follows
      color_attr_m = value;
      n_settings++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_pwdata  <= '0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[7:0] !== value) begin
         $error("color_attr readback: expected %h, actual %h", value, csr_prdata[7:0]);
         err_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // one random command, weighted toward puts; reads lean on the cursor row
   task automatic random_command();
      int roll;
      int pick;
      logic [10:0] idx;
      roll = $urandom_range(99);
      idx  = 11'($urandom_range(2047));
      if (roll < 3) begin
         // a long run of text that can wrap at the right edge
         repeat ($urandom_range(70, 95))
            send_random(CMD_PUT, pick_glyph(), 11'($urandom_range(2047)));
      end else if (roll < 78) begin
         pick = $urandom_range(99);
         if (pick < 13)      send_random(CMD_PUT, NEWLINE_CODE, idx);
         else if (pick < 19) send_random(CMD_PUT, BACKSPACE_CODE, idx);
         else if (pick < 22) send_random(CMD_PUT, NULL_CODE, idx);
         else                send_random(CMD_PUT, pick_glyph(), idx);
      end else if (roll < 94) begin
         pick = $urandom_range(99);
         if (pick < 55)
            idx = 11'(cur_row_m * SCR_COLS + $urandom_range(SCR_COLS - 1));
         else if (pick < 85)
            idx = 11'($urandom_range(SCR_CELLS - 1));
         else
            idx = 11'($urandom_range(SCR_CELLS, 2047));   // outside the store
         send_random(CMD_READ, 8'($urandom_range(255)), idx);
      end else if (roll < 97) begin
         send_random(CMD_CLEAR, 8'($urandom_range(255)), idx);
      end else begin
         send_random(CMD_UNUSED, 8'($urandom_range(255)), idx);
      end
   endtask

   // ------------------------------------------------------------------------
   // receiver: random back-pressure, paused in the quiet phase
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= jitter_on ? ($urandom_range(99) >= 29) : 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // result checker: compare each accepted item with the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      console_status_type want;
      console_status_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.col       = rsp_tdata[6:0];
         got.row       = rsp_tdata[11:7];
         got.scrolled  = rsp_tdata[12];
         got.cell_char = rsp_tdata[20:13];
         got.fg        = rsp_tdata[44:21];
         got.bg        = rsp_tdata[68:45];
         if (due_status_q.size() == 0) begin
            $error("result item with nothing expected: %h", rsp_tdata);
            err_count++;
         end else begin
            want = due_status_q.pop_front();
            if (got.col !== want.col) begin
               $error("cursor_col: expected %0d, actual %0d", want.col, got.col);
               err_count++;
            end
            if (got.row !== want.row) begin
               $error("cursor_row: expected %0d, actual %0d", want.row, got.row);
               err_count++;
            end
            if (got.scrolled !== want.scrolled) begin
               $error("scrolled: expected %0d, actual %0d", want.scrolled, got.scrolled);
               err_count++;
            end
            if (got.cell_char !== want.cell_char) begin
               $error("cell_char: expected %h, actual %h", want.cell_char, got.cell_char);
               err_count++;
            end
            if (got.fg !== want.fg) begin
               $error("fg_rgb: expected %h, actual %h", want.fg, got.fg);
               err_count++;
            end
            if (got.bg !== want.bg) begin
               $error("bg_rgb: expected %h, actual %h", want.bg, got.bg);
               err_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: cycles in a row with no item moving on either channel
   // ------------------------------------------------------------------------
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || run_done)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, due_status_q.size());
         $display("testbench: done, errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   directed_row_type directed_q [$];

   // one directed row; the status is used only where typed is set, and
   // typed rows all run at the reset color (white on black)
   task automatic add_row(input logic [1:0] cmd, input logic [7:0] code,
                          input logic [10:0] idx, input bit typed,
                          input int col, input int row, input logic [7:0] cell_char);
      directed_row_type r;
      r.cmd              = cmd;
      r.code             = code;
      r.idx              = idx;
      r.typed            = typed;
      r.status.col       = 7'(col);
      r.status.row       = 5'(row);
      r.status.scrolled  = 1'b0;
      r.status.cell_char = cell_char;
      r.status.fg        = RGB_WHITE;
      r.status.bg        = RGB_BLACK;
      directed_q.push_back(r);
   endtask

   initial begin
      logic [7:0] attr_plan [4];
      int         phase_end;

      // reset state of the console
      foreach (screen_mem[i]) screen_mem[i] = SPACE_CODE;
      cur_col_m    = 0;
      cur_row_m    = 0;
      color_attr_m = COLOR_ATTR_RESET;

      // directed table: reset contents, store edges, special cases
      add_row(CMD_READ,   8'h00,          11'd0,    1, 0, 0, SPACE_CODE);  // first cell
      add_row(CMD_READ,   8'hff,          11'd1999, 1, 0, 0, SPACE_CODE);  // last cell
      add_row(CMD_READ,   8'h00,          11'd2000, 1, 0, 0, 8'h00);       // just past the end
      add_row(CMD_READ,   8'h00,          11'd2047, 1, 0, 0, 8'h00);       // top of the index
      add_row(CMD_UNUSED, 8'hff,          11'd2047, 1, 0, 0, 8'h00);       // unused command
      add_row(CMD_PUT,    BACKSPACE_CODE, 11'd0,    1, 0, 0, 8'h00);       // backspace at col 0
      add_row(CMD_PUT,    NULL_CODE,      11'd0,    1, 0, 0, 8'h00);       // null is ignored
      add_row(CMD_PUT,    8'h41,          11'd0,    1, 1, 0, 8'h00);
      add_row(CMD_PUT,    8'hff,          11'd0,    1, 2, 0, 8'h00);       // top code
      add_row(CMD_PUT,    8'h01,          11'd0,    1, 3, 0, 8'h00);       // lowest stored code
      add_row(CMD_READ,   8'h00,          11'd0,    1, 3, 0, 8'h41);
      add_row(CMD_READ,   8'h00,          11'd1,    1, 3, 0, 8'hff);
      add_row(CMD_READ,   8'h00,          11'd2,    1, 3, 0, 8'h01);
      add_row(CMD_PUT,    BACKSPACE_CODE, 11'd0,    1, 2, 0, 8'h00);
      add_row(CMD_READ,   8'h00,          11'd2,    0, 0, 0, 8'h00);       // backspace erases nothing
      add_row(CMD_PUT,    8'h7e,          11'd0,    0, 0, 0, 8'h00);       // overwrite in place
      add_row(CMD_PUT,    NEWLINE_CODE,   11'd0,    1, 0, 1, 8'h00);
      add_row(CMD_PUT,    8'h80,          11'd0,    0, 0, 0, 8'h00);
      add_row(CMD_READ,   8'h00,          11'd80,   0, 0, 0, 8'h00);
      add_row(CMD_READ,   8'h00,          11'd2,    0, 0, 0, 8'h00);
      add_row(CMD_CLEAR,  8'h00,          11'd0,    0, 0, 0, 8'h00);       // cursor survives clear
      add_row(CMD_READ,   8'h00,          11'd80,   1, 1, 1, SPACE_CODE);
      add_row(CMD_READ,   8'h00,          11'd0,    1, 1, 1, SPACE_CODE);

      // reset held, then released; the block then clears its store on its own
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_q[i])
         send_item(directed_q[i].cmd, directed_q[i].code, directed_q[i].idx,
                   directed_q[i].typed, directed_q[i].status);
      drain_results();

      // one phase per color setting: both extremes, a mixed one, a random one;
      // the third phase runs with no idling on either side
      attr_plan = '{8'h00, 8'hff, 8'h3c, 8'($urandom_range(255))};
      for (int ph = 0; ph < 4; ph++) begin
         set_color_attr(attr_plan[ph]);
         jitter_on = (ph != 2);
         phase_end = accepted + PHASE_ITEMS;
         while (accepted < phase_end)
            random_command();
         drain_results();
      end

      run_done = 1'b1;
      repeat (20) @(posedge clock);
      $display("run: %0d items, %0d puts, %0d scrolls, %0d reads, %0d clears",
               accepted, n_puts, n_scrolls, n_reads, n_clears);
      $display("run: %0d color settings, both sides stalled at random but in one phase",
               n_settings);
      if (err_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
